// ----- hdl/rpac_pkg.sv -----
// ----------------------------------------------------------------------------
// rpac_pkg: shared types and constants for the point rotation block
// Fixed formats of the angle path, the CORDIC arctangent table and the
// quadrant codes used by the front end and the back end.
// ----------------------------------------------------------------------------
package rpac_pkg;

	// Angle input is signed Q10.16 degrees.
	localparam int unsigned ANGLE_W     = 26;
	// Working width for the wrap of the angle into one turn.
	localparam int unsigned ANG_EXT_W   = 28;
	// Width of the wrapped angle, which lies in [0, 360) degrees.
	localparam int unsigned RED_W       = 25;
	// CORDIC angle (2^-24 degree units) and Q2.30 vector widths.
	localparam int unsigned Z_W         = 32;
	localparam int unsigned XY_W        = 32;
	// Cosine and sine after the quadrant swap, with room for negation.
	localparam int unsigned CS_W        = 33;
	// Q10.16 degrees to 2^-24 degree units.
	localparam int unsigned ANG_SCALE_SH = 8;
	// The rotated offset is Q2.30 times Q16.16; drop 30 bits to get Q16.16.
	localparam int unsigned ROUND_SH    = 30;

	localparam logic signed [ANG_EXT_W-1:0] FULL_TURN    = ANG_EXT_W'(360 * 65536);
	localparam logic signed [ANG_EXT_W-1:0] QUARTER_TURN = ANG_EXT_W'(90 * 65536);
	localparam logic signed [ANG_EXT_W-1:0] TURN_45      = ANG_EXT_W'(45 * 65536);
	localparam logic signed [ANG_EXT_W-1:0] TURN_135     = ANG_EXT_W'(135 * 65536);
	localparam logic signed [ANG_EXT_W-1:0] TURN_225     = ANG_EXT_W'(225 * 65536);
	localparam logic signed [ANG_EXT_W-1:0] TURN_315     = ANG_EXT_W'(315 * 65536);

	// Inverse CORDIC gain in Q2.30.
	localparam logic signed [XY_W-1:0] GAIN_Q30 = XY_W'(652032874);

	// atan(2^-i) in units of 2^-24 degree, rounded to nearest.
	localparam logic signed [Z_W-1:0] ATAN_TAB [32] = '{
		32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
		32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
		32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
		32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
		32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
		32'sd917,       32'sd458,       32'sd229,       32'sd115,
		32'sd57,        32'sd29,        32'sd14,        32'sd7,
		32'sd4,         32'sd2,         32'sd1,         32'sd0
	};

	// Number of whole quarter turns left over after the residual is split off.
	typedef enum logic [1:0] {
		QUAD_0   = 2'd0,
		QUAD_90  = 2'd1,
		QUAD_180 = 2'd2,
		QUAD_270 = 2'd3
	} quad_t;

endpackage

// ----- hdl/rpac_front.sv -----
// ----------------------------------------------------------------------------
// rpac_front: angle reduction and offset stages
// Wraps the angle into one turn, splits it into quarter turns and a residual
// in [-45, 45) degrees, and forms the offset of the point from the pivot.
// ----------------------------------------------------------------------------
module rpac_front
	import rpac_pkg::*;
#(
	parameter int unsigned COORD_WIDTH = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_valid,
	input  logic signed [ANGLE_W-1:0]            angle_deg,
	input  logic signed [COORD_WIDTH-1:0]        pivot_x,
	input  logic signed [COORD_WIDTH-1:0]        pivot_y,
	input  logic signed [COORD_WIDTH-1:0]        point_x,
	input  logic signed [COORD_WIDTH-1:0]        point_y,
	output logic                                 out_valid,
	output logic signed [Z_W-1:0]                out_z,
	output logic [4*COORD_WIDTH+3:0]             out_side
);

	localparam int unsigned DW = COORD_WIDTH + 1;

	logic                         valid_s1, valid_s2;
	logic [RED_W-1:0]             r_s1;
	logic signed [DW-1:0]         dx_s1, dy_s1;
	logic signed [COORD_WIDTH-1:0] cx_s1, cy_s1;
	logic signed [Z_W-1:0]        z_s2;
	logic [4*COORD_WIDTH+3:0]     side_s2;

	logic signed [ANG_EXT_W-1:0]  ang_c, wrap_c, r_c, res_c;
	quad_t                        quad_c;

	// Stage 1: the angle field spans less than two turns either way, so one of
	// four fixed offsets brings it into [0, 360) degrees.
	always_comb begin
		ang_c = ANG_EXT_W'(angle_deg);
		priority if (ang_c < 0) begin
			if (ang_c + FULL_TURN < 0) begin
				wrap_c = ang_c + FULL_TURN + FULL_TURN;
			end else begin
				wrap_c = ang_c + FULL_TURN;
			end
		end else if (ang_c >= FULL_TURN) begin
			wrap_c = ang_c - FULL_TURN;
		end else begin
			wrap_c = ang_c;
		end
	end

	// Stage 2: round to the nearest quarter turn, halves going up.
	always_comb begin
		r_c = ANG_EXT_W'(r_s1);
		priority if (r_c >= TURN_315) begin
			res_c  = r_c - FULL_TURN;
			quad_c = QUAD_0;
		end else if (r_c >= TURN_225) begin
			res_c  = r_c - TURN_225 - TURN_45;
			quad_c = QUAD_270;
		end else if (r_c >= TURN_135) begin
			res_c  = r_c - TURN_135 - TURN_45;
			quad_c = QUAD_180;
		end else if (r_c >= TURN_45) begin
			res_c  = r_c - QUARTER_TURN;
			quad_c = QUAD_90;
		end else begin
			res_c  = r_c;
			quad_c = QUAD_0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1    <= wrap_c[RED_W-1:0];
			dx_s1   <= DW'(point_x) - DW'(pivot_x);
			dy_s1   <= DW'(point_y) - DW'(pivot_y);
			cx_s1   <= pivot_x;
			cy_s1   <= pivot_y;
			z_s2    <= Z_W'(res_c) <<< ANG_SCALE_SH;
			side_s2 <= {quad_c, cy_s1, cx_s1, dy_s1, dx_s1};
		end
	end

	assign out_valid = valid_s2;
	assign out_z     = z_s2;
	assign out_side  = side_s2;

endmodule

// ----- hdl/rpac_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// rpac_cordic_cell: one rotation step of the CORDIC chain
// Turns the vector by plus or minus atan(2^-SHIFT) toward zero residual angle
// and passes the item's side data to the next cell.
// ----------------------------------------------------------------------------
module rpac_cordic_cell
	import rpac_pkg::*;
#(
	parameter int unsigned SHIFT  = 0,
	parameter int unsigned SIDE_W = 132
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic signed [XY_W-1:0]   in_x,
	input  logic signed [XY_W-1:0]   in_y,
	input  logic signed [Z_W-1:0]    in_z,
	input  logic [SIDE_W-1:0]        in_side,
	output logic                     out_valid,
	output logic signed [XY_W-1:0]   out_x,
	output logic signed [XY_W-1:0]   out_y,
	output logic signed [Z_W-1:0]    out_z,
	output logic [SIDE_W-1:0]        out_side
);

	logic                   valid_q;
	logic signed [XY_W-1:0] x_q, y_q;
	logic signed [Z_W-1:0]  z_q;
	logic [SIDE_W-1:0]      side_q;
	logic signed [XY_W-1:0] xs, ys;

	// Arithmetic shifts round toward minus infinity.
	assign xs = in_x >>> SHIFT;
	assign ys = in_y >>> SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= in_side;
			if (!in_z[Z_W-1]) begin
				x_q <= in_x - ys;
				y_q <= in_y + xs;
				z_q <= in_z - ATAN_TAB[SHIFT];
			end else begin
				x_q <= in_x + ys;
				y_q <= in_y - xs;
				z_q <= in_z + ATAN_TAB[SHIFT];
			end
		end
	end

	assign out_valid = valid_q;
	assign out_x     = x_q;
	assign out_y     = y_q;
	assign out_z     = z_q;
	assign out_side  = side_q;

endmodule

// ----- hdl/rpac_back.sv -----
// ----------------------------------------------------------------------------
// rpac_back: quadrant correction, rotation products and result rounding
// Applies the quarter turns to cos and sin, forms the rotated offset exactly
// from split partial products, rounds it to Q16.16, adds the center back and
// saturates each coordinate.
// ----------------------------------------------------------------------------
module rpac_back
	import rpac_pkg::*;
#(
	parameter int unsigned COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic signed [XY_W-1:0]        in_x,
	input  logic signed [XY_W-1:0]        in_y,
	input  logic [4*COORD_WIDTH+3:0]      in_side,
	output logic                          out_valid,
	output logic signed [COORD_WIDTH-1:0] out_x,
	output logic signed [COORD_WIDTH-1:0] out_y,
	output logic                          out_ovf
);

	localparam int unsigned CW   = COORD_WIDTH;
	localparam int unsigned DW   = CW + 1;
	localparam int unsigned LO_W = DW / 2;
	localparam int unsigned HI_W = DW - LO_W;
	localparam int unsigned PL_W = LO_W + 1 + CS_W;
	localparam int unsigned PH_W = HI_W + CS_W;
	localparam int unsigned LS_W = PL_W + 1;
	localparam int unsigned HS_W = PH_W + 1;
	localparam int unsigned TW   = CW + CS_W + 3;
	localparam int unsigned RW   = TW - ROUND_SH;
	localparam int unsigned SW   = RW + 1;

	localparam logic signed [TW-1:0] HALF_LSB = TW'(1) <<< (ROUND_SH - 1);
	localparam logic signed [CW-1:0] C_MAX    = {1'b0, {(CW - 1){1'b1}}};
	localparam logic signed [CW-1:0] C_MIN    = {1'b1, {(CW - 1){1'b0}}};

	logic signed [DW-1:0] dx_in, dy_in;
	logic signed [CW-1:0] cx_in, cy_in;
	quad_t                quad_in;

	assign dx_in   = $signed(in_side[DW-1:0]);
	assign dy_in   = $signed(in_side[2*DW-1:DW]);
	assign cx_in   = $signed(in_side[2*DW+CW-1:2*DW]);
	assign cy_in   = $signed(in_side[2*DW+2*CW-1:2*DW+CW]);
	assign quad_in = quad_t'(in_side[2*DW+2*CW+1:2*DW+2*CW]);

	logic valid_s3, valid_s4, valid_s5, valid_s6;

	// Stage 3 registers.
	logic signed [CS_W-1:0] c_s3, s_s3, ns_s3;
	logic signed [DW-1:0]   dx_s3, dy_s3;
	logic signed [CW-1:0]   cx_s3, cy_s3, cx_s4, cy_s4, cx_s5, cy_s5, cx_s6, cy_s6;
	logic signed [CS_W-1:0] c_c, s_c;

	// Stage 4 registers: low and high partial products of each term.
	logic signed [PL_W-1:0] xa_lo_s4, xb_lo_s4, ya_lo_s4, yb_lo_s4;
	logic signed [PH_W-1:0] xa_hi_s4, xb_hi_s4, ya_hi_s4, yb_hi_s4;

	// Stage 5 registers.
	logic signed [LS_W-1:0] xl_s5, yl_s5;
	logic signed [HS_W-1:0] xh_s5, yh_s5;

	// Stage 6 registers.
	logic signed [RW-1:0]   rx_s6, ry_s6;

	logic signed [LO_W:0]   dx_lo_c, dy_lo_c;
	logic signed [HI_W-1:0] dx_hi_c, dy_hi_c;
	logic signed [TW-1:0]   tx_c, ty_c;
	logic signed [SW-1:0]   sx_c, sy_c;
	logic                   ovx_c, ovy_c;

	always_comb begin
		unique case (quad_in)
			QUAD_90: begin
				c_c = -CS_W'(in_y);
				s_c = CS_W'(in_x);
			end
			QUAD_180: begin
				c_c = -CS_W'(in_x);
				s_c = -CS_W'(in_y);
			end
			QUAD_270: begin
				c_c = CS_W'(in_y);
				s_c = -CS_W'(in_x);
			end
			default: begin
				c_c = CS_W'(in_x);
				s_c = CS_W'(in_y);
			end
		endcase
	end

	// The offsets split into an unsigned low half and a signed high half so
	// that no single multiplier is wider than the cosine times a half word.
	// The low half carries a zero sign bit so that its products stay signed.
	assign dx_lo_c = $signed({1'b0, dx_s3[LO_W-1:0]});
	assign dy_lo_c = $signed({1'b0, dy_s3[LO_W-1:0]});
	assign dx_hi_c = dx_s3[DW-1:LO_W];
	assign dy_hi_c = dy_s3[DW-1:LO_W];

	// Exact sum, then round to nearest with halves toward plus infinity.
	assign tx_c = TW'($signed({xh_s5, {LO_W{1'b0}}})) + TW'(xl_s5) + HALF_LSB;
	assign ty_c = TW'($signed({yh_s5, {LO_W{1'b0}}})) + TW'(yl_s5) + HALF_LSB;

	// Center added back, then clamp to the coordinate range.
	assign sx_c  = SW'(rx_s6) + SW'(cx_s6);
	assign sy_c  = SW'(ry_s6) + SW'(cy_s6);
	assign ovx_c = (sx_c > SW'(C_MAX)) || (sx_c < SW'(C_MIN));
	assign ovy_c = (sy_c > SW'(C_MAX)) || (sy_c < SW'(C_MIN));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s3 <= in_valid;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s3  <= c_c;
			s_s3  <= s_c;
			ns_s3 <= -s_c;
			dx_s3 <= dx_in;
			dy_s3 <= dy_in;
			cx_s3 <= cx_in;
			cy_s3 <= cy_in;

			xa_lo_s4 <= PL_W'(dx_lo_c * c_s3);
			xb_lo_s4 <= PL_W'(dy_lo_c * ns_s3);
			ya_lo_s4 <= PL_W'(dx_lo_c * s_s3);
			yb_lo_s4 <= PL_W'(dy_lo_c * c_s3);
			xa_hi_s4 <= dx_hi_c * c_s3;
			xb_hi_s4 <= dy_hi_c * ns_s3;
			ya_hi_s4 <= dx_hi_c * s_s3;
			yb_hi_s4 <= dy_hi_c * c_s3;
			cx_s4    <= cx_s3;
			cy_s4    <= cy_s3;

			xl_s5 <= LS_W'(xa_lo_s4) + LS_W'(xb_lo_s4);
			yl_s5 <= LS_W'(ya_lo_s4) + LS_W'(yb_lo_s4);
			xh_s5 <= HS_W'(xa_hi_s4) + HS_W'(xb_hi_s4);
			yh_s5 <= HS_W'(ya_hi_s4) + HS_W'(yb_hi_s4);
			cx_s5 <= cx_s4;
			cy_s5 <= cy_s4;

			rx_s6 <= $signed(tx_c[TW-1:ROUND_SH]);
			ry_s6 <= $signed(ty_c[TW-1:ROUND_SH]);
			cx_s6 <= cx_s5;
			cy_s6 <= cy_s5;
		end
	end

	always_comb begin
		priority if (sx_c > SW'(C_MAX)) begin
			out_x = C_MAX;
		end else if (sx_c < SW'(C_MIN)) begin
			out_x = C_MIN;
		end else begin
			out_x = sx_c[CW-1:0];
		end
		priority if (sy_c > SW'(C_MAX)) begin
			out_y = C_MAX;
		end else if (sy_c < SW'(C_MIN)) begin
			out_y = C_MIN;
		end else begin
			out_y = sy_c[CW-1:0];
		end
	end

	assign out_valid = valid_s6;
	assign out_ovf   = ovx_c || ovy_c;

endmodule

// ----- hdl/rotate_point_about_center.sv -----
// An input beat passes the front stages, the CORDIC cells, the back stages, then the output register.
// Throughput: one beat per clock unless the skid is full; each cell does one CORDIC step.
// Output backpressure parks one result in a skid register before the input side is held off.
// Reset clears only the valid flags of the pipeline; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
// rotate_point_about_center: rotation of a point about a center
// Takes a point and a center in signed Q16.16 and an angle in signed Q10.16
// degrees, and returns the point rotated counterclockwise about the center,
// saturated, with a flag that marks saturation.
// ----------------------------------------------------------------------------
module rotate_point_about_center
	import rpac_pkg::*;
#(
	parameter int unsigned CORDIC_STEPS = 24,
	parameter int unsigned COORD_WIDTH  = 32
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	// Input stream.
	input  logic                                              s_axis_tvalid,
	output logic                                              s_axis_tready,
	// From the lowest bit up: angle_deg, pivot_x, pivot_y, point_x, point_y,
	// then zero fill to a whole byte.
	input  logic [((ANGLE_W + 4*COORD_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
	// Result stream.
	output logic                                              m_axis_tvalid,
	input  logic                                              m_axis_tready,
	// From the lowest bit up: rotated_x, rotated_y, then zero fill to a byte.
	output logic [((2*COORD_WIDTH + 7) / 8) * 8 - 1:0]        m_axis_tdata,
	// From the lowest bit up: overflow.
	output logic [0:0]                                        m_axis_tuser
);

	localparam int unsigned CW     = COORD_WIDTH;
	localparam int unsigned SIDE_W = 4*CW + 4;
	localparam int unsigned OUT_TW = ((2*CW + 7) / 8) * 8;

	// The whole pipeline moves as one while the skid register is empty. A
	// result that leaves the last stage while the output register is stalled
	// lands in the skid register, and only then is the input held off.
	logic en;

	logic                   out_valid_q, skid_valid_q;
	logic signed [CW-1:0]   out_x_q, out_y_q, skid_x_q, skid_y_q;
	logic                   out_ovf_q, skid_ovf_q;

	assign en = !skid_valid_q;

	// Input unpacking.
	logic signed [ANGLE_W-1:0] angle_deg;
	logic signed [CW-1:0]      pivot_x, pivot_y, point_x, point_y;

	assign angle_deg = $signed(s_axis_tdata[ANGLE_W-1:0]);
	assign pivot_x   = $signed(s_axis_tdata[ANGLE_W+CW-1:ANGLE_W]);
	assign pivot_y   = $signed(s_axis_tdata[ANGLE_W+2*CW-1:ANGLE_W+CW]);
	assign point_x   = $signed(s_axis_tdata[ANGLE_W+3*CW-1:ANGLE_W+2*CW]);
	assign point_y   = $signed(s_axis_tdata[ANGLE_W+4*CW-1:ANGLE_W+3*CW]);

	// Chain taps: entry k feeds cell k, entry CORDIC_STEPS leaves the chain.
	logic                   ch_valid [CORDIC_STEPS+1];
	logic signed [XY_W-1:0] ch_x     [CORDIC_STEPS+1];
	logic signed [XY_W-1:0] ch_y     [CORDIC_STEPS+1];
	logic signed [Z_W-1:0]  ch_z     [CORDIC_STEPS+1];
	logic [SIDE_W-1:0]      ch_side  [CORDIC_STEPS+1];

	// Front end: wrap the angle, split off quarter turns, form the offset.
	rpac_front #(
		.COORD_WIDTH(CW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_axis_tvalid),
		.angle_deg (angle_deg),
		.pivot_x   (pivot_x),
		.pivot_y   (pivot_y),
		.point_x   (point_x),
		.point_y   (point_y),
		.out_valid (ch_valid[0]),
		.out_z     (ch_z[0]),
		.out_side  (ch_side[0])
	);

	// Every item starts the CORDIC at the inverse gain on the x axis.
	assign ch_x[0] = GAIN_Q30;
	assign ch_y[0] = '0;

	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
		rpac_cordic_cell #(
			.SHIFT  (g),
			.SIDE_W (SIDE_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (ch_valid[g]),
			.in_x      (ch_x[g]),
			.in_y      (ch_y[g]),
			.in_z      (ch_z[g]),
			.in_side   (ch_side[g]),
			.out_valid (ch_valid[g+1]),
			.out_x     (ch_x[g+1]),
			.out_y     (ch_y[g+1]),
			.out_z     (ch_z[g+1]),
			.out_side  (ch_side[g+1])
		);
	end

	// Back end: quadrant swap, products, rounding, center, saturation. Its
	// result is combinational from its last stage and is registered below.
	logic                 p_valid;
	logic signed [CW-1:0] p_x, p_y;
	logic                 p_ovf;

	rpac_back #(
		.COORD_WIDTH(CW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (ch_valid[CORDIC_STEPS]),
		.in_x      (ch_x[CORDIC_STEPS]),
		.in_y      (ch_y[CORDIC_STEPS]),
		.in_side   (ch_side[CORDIC_STEPS]),
		.out_valid (p_valid),
		.out_x     (p_x),
		.out_y     (p_y),
		.out_ovf   (p_ovf)
	);

	// Output register with one skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_valid_q && !m_axis_tready) begin
			if (en && p_valid) begin
				skid_valid_q <= 1'b1;
			end
		end else if (skid_valid_q) begin
			out_valid_q  <= 1'b1;
			skid_valid_q <= 1'b0;
		end else begin
			out_valid_q <= p_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && !m_axis_tready) begin
			if (en) begin
				skid_x_q   <= p_x;
				skid_y_q   <= p_y;
				skid_ovf_q <= p_ovf;
			end
		end else if (skid_valid_q) begin
			out_x_q   <= skid_x_q;
			out_y_q   <= skid_y_q;
			out_ovf_q <= skid_ovf_q;
		end else begin
			out_x_q   <= p_x;
			out_y_q   <= p_y;
			out_ovf_q <= p_ovf;
		end
	end

	assign s_axis_tready   = en;
	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = OUT_TW'({out_y_q, out_x_q});
	assign m_axis_tuser[0] = out_ovf_q;

`ifndef SYNTHESIS
	// The skid entry is only ever occupied behind a held output beat.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds a beat while the output register is empty");

	// The skid entry fills only when the output was stalled the cycle before.
	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready))
		else $error("skid entry filled without a stalled output beat");

	// A flagged result carries at least one clamped coordinate.
	a_ovf_means_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_ovf_q) |->
			(out_x_q == {1'b0, {(CW - 1){1'b1}}}) || (out_x_q == {1'b1, {(CW - 1){1'b0}}}) ||
			(out_y_q == {1'b0, {(CW - 1){1'b1}}}) || (out_y_q == {1'b1, {(CW - 1){1'b0}}}))
		else $error("overflow flag set on a result with no clamped coordinate");
`endif

endmodule
